[rtl/masked_key_pair_counter_defines.svh]
// Assertion helpers for the top-level file, which checks this block with them.
`ifndef MASKED_KEY_PAIR_COUNTER_DEFINES_SVH
`define MASKED_KEY_PAIR_COUNTER_DEFINES_SVH

// Condition in the same cycle implies a consequence in the same cycle.
`define MKPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define MKPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mkpc_pkg.sv]
`default_nettype none
package mkpc_pkg;
    localparam int TABLE_SIZE = 4096;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int FIELD_BITS = 30;
    localparam int NUM_FIELDS = 6;
    localparam int CNT_W      = 13;
    localparam int PAIR_W     = 23;
    localparam int STEP_W     = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [14:0]       HASH_MULT = 15'd23333;
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [PAIR_W-1:0] PAIR_MAX  = {PAIR_W{1'b1}};

    localparam logic       REQ_INSERT = 1'b0;
    localparam logic       REQ_FINISH = 1'b1;
    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_REPORT   = 2'd2;

    typedef logic [NUM_FIELDS-1:0][FIELD_BITS-1:0] rec_t;

    typedef struct packed {
        logic             req_type;
        rec_t             fld;
        logic [IDX_W-1:0] hash;
    } qent_t;
endpackage
`default_nettype wire

[rtl/mkpc_front.sv]
`default_nettype none
module mkpc_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [mkpc_pkg::NUM_FIELDS-1:0]     key_mask,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic                                s_req_type,
    input  wire mkpc_pkg::rec_t                      s_fld,
    output logic                                     q_wr,
    output mkpc_pkg::qent_t                          q_wdata,
    input  wire logic                                q_full
);
    logic                               busy_reg;
    logic [mkpc_pkg::STEP_W-1:0]        step_reg;
    logic [mkpc_pkg::IDX_W-1:0]         hash_reg, hash_next;
    logic                               req_reg;
    mkpc_pkg::rec_t                     fld_reg;
    logic [mkpc_pkg::IDX_W+14:0]        prod;
    logic [mkpc_pkg::FIELD_BITS-1:0]    cur_fld;
    logic                               cur_bit;
    logic                               done;

    assign s_tready = !busy_reg;

    always_comb begin
        cur_fld = '0;
        cur_bit = 1'b0;
        for (int j = 0; j < mkpc_pkg::NUM_FIELDS; j++) begin
            if (step_reg == mkpc_pkg::STEP_W'(j)) begin
                cur_fld = fld_reg[j];
                cur_bit = key_mask[j];
            end
        end
        // Table size is a power of two, so the modulo is the low index bits.
        prod      = {15'd0, hash_reg} * {{mkpc_pkg::IDX_W{1'b0}}, mkpc_pkg::HASH_MULT};
        hash_next = prod[mkpc_pkg::IDX_W-1:0];
        if (cur_bit) begin
            hash_next = hash_next + cur_fld[mkpc_pkg::IDX_W-1:0] + mkpc_pkg::IDX_W'(1);
        end
    end

    assign done = busy_reg && (req_reg == mkpc_pkg::REQ_FINISH ||
                               step_reg == mkpc_pkg::STEP_W'(mkpc_pkg::NUM_FIELDS));
    assign q_wr = done && !q_full;
    assign q_wdata = '{req_type: req_reg, fld: fld_reg, hash: hash_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            busy_reg <= 1'b1;
        end else if (q_wr) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg  <= s_req_type;
            fld_reg  <= s_fld;
            hash_reg <= '0;
            step_reg <= '0;
        end else if (busy_reg && !done) begin
            hash_reg <= hash_next;
            step_reg <= step_reg + mkpc_pkg::STEP_W'(1);
        end
    end
endmodule
`default_nettype wire

[rtl/mkpc_fifo.sv]
`default_nettype none
module mkpc_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr,
    input  wire mkpc_pkg::qent_t  wdata,
    output logic                  full,
    input  wire logic             rd,
    output mkpc_pkg::qent_t       rdata,
    output logic                  valid
);
    mkpc_pkg::qent_t                 buf_reg [mkpc_pkg::QDEPTH];
    logic [mkpc_pkg::QPTR_W-1:0]     wp_reg, rp_reg;
    logic [mkpc_pkg::QPTR_W:0]       cnt_reg;

    assign full  = cnt_reg == (mkpc_pkg::QPTR_W+1)'(mkpc_pkg::QDEPTH);
    assign valid = cnt_reg != '0;
    assign rdata = buf_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + mkpc_pkg::QPTR_W'(1);
            if (rd) rp_reg <= rp_reg + mkpc_pkg::QPTR_W'(1);
            if (wr && !rd) cnt_reg <= cnt_reg + (mkpc_pkg::QPTR_W+1)'(1);
            else if (rd && !wr) cnt_reg <= cnt_reg - (mkpc_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) buf_reg[wp_reg] <= wdata;
    end
endmodule
`default_nettype wire

[rtl/mkpc_back.sv]
`default_nettype none
module mkpc_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [mkpc_pkg::NUM_FIELDS-1:0] key_mask,
    input  wire logic                            q_valid,
    input  wire mkpc_pkg::qent_t                 q_rdata,
    output logic                                 q_rd,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [1:0]                           m_status,
    output logic [mkpc_pkg::PAIR_W-1:0]          m_pair
);
    localparam int IW = mkpc_pkg::IDX_W;
    localparam int CW = mkpc_pkg::CNT_W;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PRD  = 3'd2;
    localparam logic [2:0] S_PCMP = 3'd3;
    localparam logic [2:0] S_FLST = 3'd4;
    localparam logic [2:0] S_FCNT = 3'd5;
    localparam logic [2:0] S_FACC = 3'd6;
    localparam logic [2:0] S_FADD = 3'd7;

    logic [CW-1:0]         cnt_mem [mkpc_pkg::TABLE_SIZE];
    mkpc_pkg::rec_t        key_mem [mkpc_pkg::TABLE_SIZE];
    logic [IW-1:0]         lst_mem [mkpc_pkg::TABLE_SIZE];

    logic [2:0]            st_reg, st_next;
    logic [IW-1:0]         pos_reg, probe_reg, slot_reg;
    logic [IW:0]           used_reg, idx_reg;
    logic [mkpc_pkg::PAIR_W-1:0] sum_reg;
    logic [2*CW-1:0]       prod_reg;
    mkpc_pkg::qent_t       ent_reg;
    logic [CW-1:0]         cnt_rd_reg;
    mkpc_pkg::rec_t        key_rd_reg;
    logic [IW-1:0]         lst_rd_reg;
    logic                  m_tvalid_reg;
    logic [1:0]            m_status_reg;
    logic [mkpc_pkg::PAIR_W-1:0] m_pair_reg;

    logic                  cnt_we;
    logic [IW-1:0]         cnt_waddr, cnt_raddr;
    logic [CW-1:0]         cnt_wdata;
    logic                  match;

    assign m_tvalid = m_tvalid_reg;
    assign m_status = m_status_reg;
    assign m_pair   = m_pair_reg;
    assign q_rd     = (st_reg == S_IDLE) && q_valid && !m_tvalid_reg;

    always_comb begin
        match = 1'b1;
        for (int j = 0; j < mkpc_pkg::NUM_FIELDS; j++) begin
            if (key_mask[j] && key_rd_reg[j] != ent_reg.fld[j]) match = 1'b0;
        end
    end

    assign cnt_raddr = (st_reg == S_FCNT) ? lst_rd_reg : pos_reg;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = pos_reg;
        cnt_wdata = '0;
        unique case (st_reg)
            S_CLR: cnt_we = 1'b1;
            S_PCMP: begin
                if (cnt_rd_reg == '0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = CW'(1);
                end else if (match && cnt_rd_reg != mkpc_pkg::COUNT_MAX) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rd_reg + CW'(1);
                end
            end
            S_FACC: begin
                cnt_we    = 1'b1;
                cnt_waddr = slot_reg;
            end
            default: cnt_we = 1'b0;
        endcase
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_CLR:  if (pos_reg == {IW{1'b1}}) st_next = S_IDLE;
            S_IDLE: if (q_rd) st_next = (q_rdata.req_type == mkpc_pkg::REQ_FINISH) ?
                                        S_FLST : S_PRD;
            S_PRD:  st_next = S_PCMP;
            S_PCMP: begin
                if (cnt_rd_reg == '0 || match || probe_reg == {IW{1'b1}}) st_next = S_IDLE;
                else st_next = S_PRD;
            end
            S_FLST: st_next = (idx_reg == used_reg) ? S_IDLE : S_FCNT;
            S_FCNT: st_next = S_FACC;
            S_FACC: st_next = S_FADD;
            S_FADD: st_next = S_FLST;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_CLR;
            pos_reg      <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            unique case (st_reg)
                S_CLR: pos_reg <= pos_reg + IW'(1);
                S_IDLE: if (q_rd) pos_reg <= q_rdata.hash;
                S_PCMP: begin
                    if (cnt_rd_reg == '0) begin
                        used_reg     <= used_reg + (IW+1)'(1);
                        m_tvalid_reg <= 1'b1;
                    end else if (match || probe_reg == {IW{1'b1}}) begin
                        m_tvalid_reg <= 1'b1;
                    end else begin
                        pos_reg <= pos_reg + IW'(1);
                    end
                end
                S_FLST: begin
                    if (idx_reg == used_reg) begin
                        used_reg     <= '0;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload side: no reset needed.
    logic [2*CW:0] sum_wide;
    assign sum_wide = {{(2*CW+1-mkpc_pkg::PAIR_W){1'b0}}, sum_reg} +
                      {2'b00, prod_reg[2*CW-1:1]};

    always_ff @(posedge aclk) begin
        unique case (st_reg)
            S_IDLE: begin
                ent_reg   <= q_rdata;
                probe_reg <= '0;
                idx_reg   <= '0;
                sum_reg   <= '0;
            end
            S_PCMP: begin
                probe_reg <= probe_reg + IW'(1);
                if (cnt_rd_reg == '0) begin
                    m_status_reg <= mkpc_pkg::STATUS_INSERTED;
                    m_pair_reg   <= '0;
                end else if (match) begin
                    m_status_reg <= mkpc_pkg::STATUS_INSERTED;
                    m_pair_reg   <= '0;
                end else if (probe_reg == {IW{1'b1}}) begin
                    m_status_reg <= mkpc_pkg::STATUS_FULL;
                    m_pair_reg   <= '0;
                end
            end
            S_FLST: begin
                m_status_reg <= mkpc_pkg::STATUS_REPORT;
                m_pair_reg   <= sum_reg;
            end
            S_FCNT: slot_reg <= lst_rd_reg;
            S_FACC: prod_reg <= {{CW{1'b0}}, cnt_rd_reg} *
                                {{CW{1'b0}}, cnt_rd_reg - CW'(1)};
            S_FADD: begin
                idx_reg <= idx_reg + (IW+1)'(1);
                if (sum_wide > {{(2*CW+1-mkpc_pkg::PAIR_W){1'b0}}, mkpc_pkg::PAIR_MAX})
                    sum_reg <= mkpc_pkg::PAIR_MAX;
                else sum_reg <= sum_wide[mkpc_pkg::PAIR_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        cnt_rd_reg <= cnt_mem[cnt_raddr];
        key_rd_reg <= key_mem[pos_reg];
        lst_rd_reg <= lst_mem[idx_reg[IW-1:0]];
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        if (st_reg == S_PCMP && cnt_rd_reg == '0) begin
            key_mem[pos_reg]            <= ent_reg.fld;
            lst_mem[used_reg[IW-1:0]]   <= pos_reg;
        end
    end
endmodule
`default_nettype wire

[rtl/masked_key_pair_counter.sv]
// Masked key pair counter.
// Input stream (s_*): one word per request. tuser is the request kind
// (insert or finish), tdata carries the six record fields. Result stream
// (m_*): exactly one word per request, tuser the status (inserted, dropped
// because the table is full, or pair report) and tdata the pair count.
// An insert takes six hash steps on one multiplier in the front; each
// probe in the back passes a read state and a compare state, set by the
// registered read of the slot memories. The front takes no new word
// until the current one is queued. A finish walks the list of used slots,
// summing and clearing each count, then reports and leaves the table empty.
// A two-entry queue sits between the hashing front and the table back, so
// the front keeps accepting while a result waits on m_tready; the back holds
// its result register and stops taking queued work until it is taken.
// After reset one pass over all 4096 slots clears the counts; no result is
// produced then (words still queue). key_mask resets to all fields. At APB
// address 0 the user must write it only while idle; no check enforces it.
`default_nettype none
`include "masked_key_pair_counter_defines.svh"
module masked_key_pair_counter (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [183:0] s_tdata,  // field_0 .. field_5, 30 bits each, zero pad
    input  wire logic         s_tuser,  // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,  // pair_count, zero pad
    output logic [1:0]        m_tuser   // status
);
    logic [mkpc_pkg::NUM_FIELDS-1:0] key_mask_reg;
    mkpc_pkg::rec_t                  s_fld;
    logic                            q_wr, q_full, q_rd, q_valid;
    mkpc_pkg::qent_t                 q_wdata, q_rdata;
    logic [mkpc_pkg::PAIR_W-1:0]     pair;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {26'd0, key_mask_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_mask_reg <= '1;
        end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
            key_mask_reg <= pwdata[mkpc_pkg::NUM_FIELDS-1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < mkpc_pkg::NUM_FIELDS; j++) begin
            s_fld[j] = s_tdata[j*mkpc_pkg::FIELD_BITS +: mkpc_pkg::FIELD_BITS];
        end
    end

    mkpc_front u_front (
        .aclk, .aresetn, .key_mask(key_mask_reg),
        .s_tvalid, .s_tready, .s_req_type(s_tuser), .s_fld,
        .q_wr, .q_wdata, .q_full
    );

    mkpc_fifo u_fifo (
        .aclk, .aresetn, .wr(q_wr), .wdata(q_wdata), .full(q_full),
        .rd(q_rd), .rdata(q_rdata), .valid(q_valid)
    );

    mkpc_back u_back (
        .aclk, .aresetn, .key_mask(key_mask_reg),
        .q_valid, .q_rdata, .q_rd,
        .m_tvalid, .m_tready, .m_status(m_tuser), .m_pair(pair)
    );

    assign m_tdata = {1'b0, pair};

    `MKPC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `MKPC_ASSERT_NOW(a_zero, m_tvalid && m_tuser != mkpc_pkg::STATUS_REPORT, m_tdata == 24'd0, "pair count on non-report")
    `MKPC_ASSERT_NOW(a_qpush, q_wr, !q_full, "push into full queue")
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int MASK_ADDR = 0;

    logic         aclk;
    logic         aresetn;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [183:0] s_tdata;  // field_0 .. field_5, 30 bits each, zero pad
    logic         s_tuser;  // req_type
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;  // pair_count, zero pad
    logic [1:0]   m_tuser;  // status

    masked_key_pair_counter dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    typedef struct packed {
        logic [1:0]                  status;
        logic [mkpc_pkg::PAIR_W-1:0] pairs;
    } outcome_t;

    // Shadow of the block's table.
    int unsigned     grp_count [mkpc_pkg::TABLE_SIZE];
    mkpc_pkg::rec_t  grp_key   [mkpc_pkg::TABLE_SIZE];
    int unsigned     taken_slots[$];
    logic [5:0]      mask_shadow;

    outcome_t     pending[$];
    int           mismatches;
    int           results_seen;
    bit           hold_off_long;
    bit           recv_quiet;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic outcome_t predict_group_step(logic req, mkpc_pkg::rec_t rec);
        outcome_t o;
        longint unsigned h, sum, c;
        int unsigned pos;
        bit hit;
        o.status = mkpc_pkg::STATUS_INSERTED;
        o.pairs  = '0;
        if (req == mkpc_pkg::REQ_FINISH) begin
            sum = 0;
            foreach (taken_slots[i]) begin
                c = grp_count[taken_slots[i]];
                if (c > 0) sum += c * (c - 1) / 2;
                grp_count[taken_slots[i]] = 0;
            end
            taken_slots.delete();
            o.status = mkpc_pkg::STATUS_REPORT;
            o.pairs  = (sum > 64'(mkpc_pkg::PAIR_MAX)) ? mkpc_pkg::PAIR_MAX :
                                                         mkpc_pkg::PAIR_W'(sum);
            return o;
        end
        h = 0;
        for (int j = 0; j < mkpc_pkg::NUM_FIELDS; j++) begin
            h = (h * 23333) % mkpc_pkg::TABLE_SIZE;
            if (mask_shadow[j]) h = (h + rec[j] + 1) % mkpc_pkg::TABLE_SIZE;
        end
        pos = int'(h);
        for (int p = 0; p < mkpc_pkg::TABLE_SIZE; p++) begin
            if (grp_count[pos] == 0) begin
                grp_key[pos] = rec;
                taken_slots.push_back(pos);
                grp_count[pos] = 1;
                return o;
            end
            hit = 1'b1;
            for (int j = 0; j < mkpc_pkg::NUM_FIELDS; j++)
                if (mask_shadow[j] && grp_key[pos][j] != rec[j]) hit = 1'b0;
            if (hit) begin
                if (grp_count[pos] < 8191) grp_count[pos]++;
                return o;
            end
            pos = (pos + 1) % mkpc_pkg::TABLE_SIZE;
        end
        o.status = mkpc_pkg::STATUS_FULL;
        return o;
    endfunction

    task automatic write_mask(logic [5:0] value);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(MASK_ADDR); pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mask_shadow = value;
    endtask

    task automatic send_word(logic req, mkpc_pkg::rec_t rec, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, rec};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending.push_back(predict_group_step(req, rec));
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (40) @(posedge aclk);
    endtask

    function automatic mkpc_pkg::rec_t random_rec(int spread);
        mkpc_pkg::rec_t r;
        for (int j = 0; j < mkpc_pkg::NUM_FIELDS; j++)
            r[j] = (spread == 0) ? mkpc_pkg::FIELD_BITS'({$urandom, $urandom})
                                 : mkpc_pkg::FIELD_BITS'($urandom_range(spread - 1, 0));
        return r;
    endfunction

    // Receiver: random stalls, with one long hold-off when asked.
    initial begin
        outcome_t want;
        int       wait_n;
        m_tready = 1'b0;
        forever begin
            if (hold_off_long) begin
                wait_n = 300;
                hold_off_long = 1'b0;
            end else begin
                wait_n = recv_quiet ? 0 : $urandom_range(14, 0);
            end
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d pairs %0d", m_tuser, m_tdata);
            end else begin
                want = pending.pop_front();
                if (m_tuser !== want.status || m_tdata !== {1'b0, want.pairs}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d pairs %0d, got %0d %0d",
                                 want.status, want.pairs, m_tuser, m_tdata);
                end
            end
        end
    end

    typedef struct {
        logic           req;
        mkpc_pkg::rec_t rec;
        bit             typed;
        outcome_t       want;
    } stim_row_t;

    stim_row_t plan[$];

    function automatic stim_row_t row(logic req, mkpc_pkg::rec_t rec, bit typed,
                                      logic [1:0] st, logic [mkpc_pkg::PAIR_W-1:0] pr);
        stim_row_t r;
        r.req = req; r.rec = rec; r.typed = typed;
        r.want.status = st; r.want.pairs = pr;
        return r;
    endfunction

    initial begin
        mkpc_pkg::rec_t all_ones, zeros, rr;
        outcome_t got;
        int n, spread;
        logic [5:0] m;
        all_ones = '1;
        zeros    = '0;
        mismatches = 0; results_seen = 0;
        hold_off_long = 1'b0; recv_quiet = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = mkpc_pkg::REQ_INSERT;
        mask_shadow = 6'd63;
        foreach (grp_count[i]) grp_count[i] = 0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: finish on empty, extremes, repeats, finish fields ignored.
        plan.push_back(row(mkpc_pkg::REQ_FINISH, zeros, 1, mkpc_pkg::STATUS_REPORT, 0));
        plan.push_back(row(mkpc_pkg::REQ_INSERT, zeros, 1, mkpc_pkg::STATUS_INSERTED, 0));
        plan.push_back(row(mkpc_pkg::REQ_INSERT, zeros, 1, mkpc_pkg::STATUS_INSERTED, 0));
        plan.push_back(row(mkpc_pkg::REQ_INSERT, all_ones, 1, mkpc_pkg::STATUS_INSERTED, 0));
        plan.push_back(row(mkpc_pkg::REQ_INSERT, all_ones, 1, mkpc_pkg::STATUS_INSERTED, 0));
        plan.push_back(row(mkpc_pkg::REQ_INSERT, all_ones, 1, mkpc_pkg::STATUS_INSERTED, 0));
        plan.push_back(row(mkpc_pkg::REQ_FINISH, all_ones, 1, mkpc_pkg::STATUS_REPORT, 4));
        for (int k = 0; k < 8; k++)
            plan.push_back(row(mkpc_pkg::REQ_INSERT, random_rec(2), 0,
                               mkpc_pkg::STATUS_INSERTED, 0));
        plan.push_back(row(mkpc_pkg::REQ_FINISH, random_rec(0), 0,
                           mkpc_pkg::STATUS_REPORT, 0));
        foreach (plan[i]) begin
            got = predict_group_step(plan[i].req, plan[i].rec);
            if (plan[i].typed && got != plan[i].want)
                $display("directed row %0d disagrees with the typed value", i);
        end
        // Replay on the block: clear the shadow, then resend each row through send_word.
        foreach (grp_count[i]) grp_count[i] = 0;
        taken_slots.delete();
        foreach (plan[i]) begin
            send_word(plan[i].req, plan[i].rec, $urandom_range(14, 0));
            if (plan[i].typed) pending[pending.size() - 1] = plan[i].want;
        end
        wait_drained();

        // Several masks, extremes first; each phase ends with a finish.
        for (int ph = 0; ph < 14; ph++) begin
            m = (ph == 0) ? 6'd0 : (ph == 1) ? 6'd63 : (ph == 2) ? 6'd1 : 6'($urandom);
            write_mask(m);
            n = 120;
            spread = (ph % 3 == 0) ? 0 : $urandom_range(6, 2);
            if (ph == 4) hold_off_long = 1'b1;
            if (ph == 6) recv_quiet = 1'b1;
            if (ph == 8) recv_quiet = 1'b0;
            for (int k = 0; k < n; k++) begin
                rr = random_rec(spread);
                if ($urandom_range(9, 0) == 0) rr = random_rec(0);
                send_word(($urandom_range(40, 0) == 0) ? mkpc_pkg::REQ_FINISH :
                                                         mkpc_pkg::REQ_INSERT, rr,
                          ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(14, 0));
            end
            send_word(mkpc_pkg::REQ_FINISH, random_rec(0), $urandom_range(14, 0));
            // Mask change once the phase's finish has emptied the table, then inserts and a finish.
            if (ph == 9) begin
                wait_drained();
                write_mask(6'($urandom));
                for (int k = 0; k < 30; k++)
                    send_word(mkpc_pkg::REQ_INSERT, random_rec(3), 0);
                send_word(mkpc_pkg::REQ_FINISH, zeros, 0);
            end
            wait_drained();
        end

        wait_drained();
        if (pending.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/mkpc_pkg.sv
rtl/mkpc_front.sv
rtl/mkpc_fifo.sv
rtl/mkpc_back.sv
rtl/masked_key_pair_counter.sv
dv/tb.sv
